/* design/hrpd_pkg.sv */
// Package: shared constants, control word types and microprogram ROM for the HSV/RGB LED driver.
package hrpd_pkg;

	localparam int DUTY_BITS = 12;
	localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

	localparam int LVL_W = 8;
	localparam int A_W = LVL_W + DUTY_BITS;
	localparam int B_W = 25;
	localparam int P_W = A_W + B_W;

	// x/255 == (x*M255) >> 32 exactly for x < 2**24
	localparam int M255_SHIFT = 32;
	localparam logic [B_W-1:0] M255 = B_W'((64'd1 << M255_SHIFT) / 64'd255 + 64'd1);
	// x/60 == (x*R60) >> 20 exactly for x < 2**14
	localparam int R60_SHIFT = 20;
	localparam logic [B_W-1:0] R60 = B_W'((64'd1 << R60_SHIFT) / 64'd60 + 64'd1);

	localparam logic [8:0] HUE_WRAP = 9'd360;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_BASE = 1'd1;

	typedef enum logic [2:0] {
		CMD_SET_ALL   = 3'd0,
		CMD_SET_RED   = 3'd1,
		CMD_SET_GREEN = 3'd2,
		CMD_SET_BLUE  = 3'd3,
		CMD_SET_HSV   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		A_ZERO, A_VAL, A_PROD, A_CPROD, A_RED, A_GREEN, A_BLUE
	} a_sel_t;

	typedef enum logic [2:0] {
		B_ZERO, B_SAT, B_M255, B_T, B_R60, B_DMAX
	} b_sel_t;

	typedef enum logic [2:0] {
		ST_NONE, ST_C, ST_X, ST_MIX, ST_DR, ST_DG, ST_DB, ST_OUT
	} st_sel_t;

	typedef enum logic [1:0] {
		JC_NONE, JC_NO_START, JC_NOT_HSV, JC_OUT_BUSY
	} jc_t;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd1;
	localparam logic [STEP_W-1:0] STEP_DUTY = 4'd8;
	localparam logic [STEP_W-1:0] STEP_OUT = 4'd15;

	typedef struct packed {
		logic              take_in;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		st_sel_t           st_sel;
		jc_t               jc;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic hsv;
		logic out_free;
	} stat_t;

	// microprogram: one control word per step, 16 steps, last step wraps to idle
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{1'b0, A_ZERO, B_ZERO, ST_NONE, JC_NONE, STEP_IDLE};
		unique case (step)
			4'd0:  w = '{1'b1, A_ZERO,  B_ZERO, ST_NONE, JC_NO_START, STEP_IDLE};
			4'd1:  w = '{1'b0, A_ZERO,  B_ZERO, ST_NONE, JC_NOT_HSV,  STEP_DUTY};
			4'd2:  w = '{1'b0, A_VAL,   B_SAT,  ST_NONE, JC_NONE,     STEP_IDLE};
			4'd3:  w = '{1'b0, A_PROD,  B_M255, ST_NONE, JC_NONE,     STEP_IDLE};
			4'd4:  w = '{1'b0, A_CPROD, B_T,    ST_C,    JC_NONE,     STEP_IDLE};
			4'd5:  w = '{1'b0, A_PROD,  B_R60,  ST_NONE, JC_NONE,     STEP_IDLE};
			4'd6:  w = '{1'b0, A_ZERO,  B_ZERO, ST_X,    JC_NONE,     STEP_IDLE};
			4'd7:  w = '{1'b0, A_ZERO,  B_ZERO, ST_MIX,  JC_NONE,     STEP_IDLE};
			4'd8:  w = '{1'b0, A_RED,   B_DMAX, ST_NONE, JC_NONE,     STEP_IDLE};
			4'd9:  w = '{1'b0, A_PROD,  B_M255, ST_NONE, JC_NONE,     STEP_IDLE};
			4'd10: w = '{1'b0, A_GREEN, B_DMAX, ST_DR,   JC_NONE,     STEP_IDLE};
			4'd11: w = '{1'b0, A_PROD,  B_M255, ST_NONE, JC_NONE,     STEP_IDLE};
			4'd12: w = '{1'b0, A_BLUE,  B_DMAX, ST_DG,   JC_NONE,     STEP_IDLE};
			4'd13: w = '{1'b0, A_PROD,  B_M255, ST_NONE, JC_NONE,     STEP_IDLE};
			4'd14: w = '{1'b0, A_ZERO,  B_ZERO, ST_DB,   JC_NONE,     STEP_IDLE};
			4'd15: w = '{1'b0, A_ZERO,  B_ZERO, ST_OUT,  JC_OUT_BUSY, STEP_OUT};
		endcase
		return w;
	endfunction

endpackage

/* design/hrpd_if.sv */
// Interfaces: command input channel and duty output channel.
interface hrpd_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] level;
	logic [8:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source (
		output valid, command, red_in, green_in, blue_in, level, hue, saturation, brightness,
		input  ready
	);
	modport sink (
		input  valid, command, red_in, green_in, blue_in, level, hue, saturation, brightness,
		output ready
	);
endinterface

interface hrpd_out_if;
	logic                           valid;
	logic                           ready;
	logic [3:0]                     pwm_channel;
	logic [hrpd_pkg::DUTY_BITS-1:0] first_duty;
	logic [hrpd_pkg::DUTY_BITS-1:0] second_duty;
	logic [hrpd_pkg::DUTY_BITS-1:0] third_duty;

	modport source (
		output valid, pwm_channel, first_duty, second_duty, third_duty,
		input  ready
	);
	modport sink (
		input  valid, pwm_channel, first_duty, second_duty, third_duty,
		output ready
	);
endinterface

/* design/hsv_rgb_led_pwm_driver.sv */
// Top level: HSV/RGB LED level holder with 12-bit PWM duty output.
//
// channel   dir   handshake      payload
// cfg       in    cfg_we         cfg_index, cfg_data
// in_ch     in    valid/ready    command, red_in, green_in, blue_in, level, hue, saturation,
//                                brightness
// out_ch    out   valid/ready    pwm_channel, first_duty, second_duty, third_duty
//
// One item at a time through a 16-word microprogram, one word per cycle, sharing one
// 20x25 multiplier for val*sat/255, C*t/60 and the three level*4095/255 duties.
// HSV items run all 16 steps; other commands skip the conversion steps and run
// 10 steps.
// The last step holds while the output register is full and not taken; once it loads,
// the next item can be taken while that result waits.
// arst_n clears levels, config and the step counter; no clearing pass.
module hsv_rgb_led_pwm_driver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrpd_pkg::CFG_DATA_W-1:0] cfg_data,
	hrpd_in_if.sink                         in_ch,
	hrpd_out_if.source                      out_ch
);

	hrpd_pkg::ctrl_t ctrl;
	hrpd_pkg::stat_t stat;

	hrpd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	hrpd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

endmodule

/* design/hrpd_useq.sv */
// Microsequencer: step counter, control ROM and conditional jumps.
module hrpd_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  hrpd_pkg::stat_t stat,
	output hrpd_pkg::ctrl_t ctrl
);

	logic [hrpd_pkg::STEP_W-1:0] step_q;
	logic [hrpd_pkg::STEP_W-1:0] step_d;
	logic                        jump;

	assign ctrl = hrpd_pkg::ucode(step_q);

	always_comb begin
		unique case (ctrl.jc)
			hrpd_pkg::JC_NONE:     jump = 1'b0;
			hrpd_pkg::JC_NO_START: jump = !stat.start;
			hrpd_pkg::JC_NOT_HSV:  jump = !stat.hsv;
			hrpd_pkg::JC_OUT_BUSY: jump = !stat.out_free;
			default:               jump = 1'b0;
		endcase
		step_d = jump ? ctrl.target : hrpd_pkg::STEP_W'(step_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hrpd_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		stat.start |=> step_q == hrpd_pkg::STEP_DISPATCH)
		else $error("transfer did not start the program");

	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == hrpd_pkg::STEP_DISPATCH && !stat.hsv) |=> step_q == hrpd_pkg::STEP_DUTY)
		else $error("non-HSV command ran conversion steps");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == hrpd_pkg::STEP_OUT && !stat.out_free) |=> step_q == hrpd_pkg::STEP_OUT)
		else $error("left output step while output busy");

endmodule

/* design/hrpd_dpath.sv */
// Datapath: level registers, config, shared multiplier, HSV mix and output register.
module hrpd_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hrpd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hrpd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  hrpd_pkg::ctrl_t                    ctrl,
	output hrpd_pkg::stat_t                    stat,
	hrpd_in_if.sink                            in_ch,
	hrpd_out_if.source                         out_ch
);

	logic       order_q;
	logic [3:0] base_q;
	logic [7:0] red_q, green_q, blue_q;
	logic       hsv_q;

	logic [7:0] val_q, sat_q, c_q, x_q;
	logic [2:0] sector_q;
	logic [5:0] t_q;

	logic [hrpd_pkg::P_W-1:0]       prod_q;
	logic [hrpd_pkg::DUTY_BITS-1:0] dr_q, dg_q, db_q;
	logic                           out_valid_q;

	logic                     start, out_free;
	logic [8:0]               hue_w, base60;
	logic [2:0]               sector;
	logic [5:0]               r60, t;
	logic [hrpd_pkg::A_W-1:0] a_op;
	logic [hrpd_pkg::B_W-1:0] b_op;
	logic [7:0]               m, mix_r, mix_g, mix_b;

	assign start = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = ctrl.take_in;
	assign out_ch.valid = out_valid_q;
	assign stat = '{start: start, hsv: hsv_q, out_free: out_free};

	// hue wrap, sector and distance-from-edge term
	always_comb begin
		hue_w = (in_ch.hue >= hrpd_pkg::HUE_WRAP) ? 9'(in_ch.hue - hrpd_pkg::HUE_WRAP) : in_ch.hue;
		priority if (hue_w >= 9'd300) sector = 3'd5;
		else if (hue_w >= 9'd240) sector = 3'd4;
		else if (hue_w >= 9'd180) sector = 3'd3;
		else if (hue_w >= 9'd120) sector = 3'd2;
		else if (hue_w >= 9'd60) sector = 3'd1;
		else sector = 3'd0;
		unique case (sector)
			3'd0:    base60 = 9'd0;
			3'd1:    base60 = 9'd60;
			3'd2:    base60 = 9'd120;
			3'd3:    base60 = 9'd180;
			3'd4:    base60 = 9'd240;
			default: base60 = 9'd300;
		endcase
		r60 = 6'(hue_w - base60);
		t = sector[0] ? 6'(6'd60 - r60) : r60;
	end

	always_comb begin
		unique case (ctrl.a_sel)
			hrpd_pkg::A_VAL:   a_op = hrpd_pkg::A_W'(val_q);
			hrpd_pkg::A_PROD:  a_op = prod_q[hrpd_pkg::A_W-1:0];
			hrpd_pkg::A_CPROD: a_op = hrpd_pkg::A_W'(prod_q[hrpd_pkg::M255_SHIFT +: 8]);
			hrpd_pkg::A_RED:   a_op = hrpd_pkg::A_W'(red_q);
			hrpd_pkg::A_GREEN: a_op = hrpd_pkg::A_W'(green_q);
			hrpd_pkg::A_BLUE:  a_op = hrpd_pkg::A_W'(blue_q);
			default:           a_op = '0;
		endcase
		unique case (ctrl.b_sel)
			hrpd_pkg::B_SAT:  b_op = hrpd_pkg::B_W'(sat_q);
			hrpd_pkg::B_M255: b_op = hrpd_pkg::M255;
			hrpd_pkg::B_T:    b_op = hrpd_pkg::B_W'(t_q);
			hrpd_pkg::B_R60:  b_op = hrpd_pkg::R60;
			hrpd_pkg::B_DMAX: b_op = hrpd_pkg::B_W'(hrpd_pkg::DUTY_MAX);
			default:          b_op = '0;
		endcase
	end

	always_comb begin
		m = 8'(val_q - c_q);
		unique case (sector_q)
			3'd0:    begin mix_r = c_q;  mix_g = x_q;  mix_b = 8'd0; end
			3'd1:    begin mix_r = x_q;  mix_g = c_q;  mix_b = 8'd0; end
			3'd2:    begin mix_r = 8'd0; mix_g = c_q;  mix_b = x_q;  end
			3'd3:    begin mix_r = 8'd0; mix_g = x_q;  mix_b = c_q;  end
			3'd4:    begin mix_r = x_q;  mix_g = 8'd0; mix_b = c_q;  end
			default: begin mix_r = c_q;  mix_g = 8'd0; mix_b = x_q;  end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			base_q <= 4'd0;
			red_q <= 8'd0;
			green_q <= 8'd0;
			blue_q <= 8'd0;
			hsv_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					hrpd_pkg::CFG_COLOR_ORDER:  order_q <= cfg_data[0];
					hrpd_pkg::CFG_CHANNEL_BASE: base_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (start) begin
				hsv_q <= (hrpd_pkg::cmd_t'(in_ch.command) == hrpd_pkg::CMD_SET_HSV);
				unique case (hrpd_pkg::cmd_t'(in_ch.command))
					hrpd_pkg::CMD_SET_ALL: begin
						red_q <= in_ch.red_in;
						green_q <= in_ch.green_in;
						blue_q <= in_ch.blue_in;
					end
					hrpd_pkg::CMD_SET_RED:   red_q <= in_ch.level;
					hrpd_pkg::CMD_SET_GREEN: green_q <= in_ch.level;
					hrpd_pkg::CMD_SET_BLUE:  blue_q <= in_ch.level;
					default: ;
				endcase
			end else if (ctrl.st_sel == hrpd_pkg::ST_MIX) begin
				red_q <= 8'(mix_r + m);
				green_q <= 8'(mix_g + m);
				blue_q <= 8'(mix_b + m);
			end
			if (ctrl.st_sel == hrpd_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= hrpd_pkg::P_W'(a_op) * hrpd_pkg::P_W'(b_op);
		if (start) begin
			val_q <= in_ch.brightness;
			sat_q <= in_ch.saturation;
			sector_q <= sector;
			t_q <= t;
		end
		unique case (ctrl.st_sel)
			hrpd_pkg::ST_C:  c_q <= prod_q[hrpd_pkg::M255_SHIFT +: 8];
			hrpd_pkg::ST_X:  x_q <= prod_q[hrpd_pkg::R60_SHIFT +: 8];
			hrpd_pkg::ST_DR: dr_q <= prod_q[hrpd_pkg::M255_SHIFT +: hrpd_pkg::DUTY_BITS];
			hrpd_pkg::ST_DG: dg_q <= prod_q[hrpd_pkg::M255_SHIFT +: hrpd_pkg::DUTY_BITS];
			hrpd_pkg::ST_DB: db_q <= prod_q[hrpd_pkg::M255_SHIFT +: hrpd_pkg::DUTY_BITS];
			default: ;
		endcase
		if (ctrl.st_sel == hrpd_pkg::ST_OUT && out_free) begin
			out_ch.pwm_channel <= base_q;
			out_ch.first_duty <= order_q ? dr_q : dg_q;
			out_ch.second_duty <= order_q ? dg_q : dr_q;
			out_ch.third_duty <= db_q;
		end
	end

	a_mix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.st_sel == hrpd_pkg::ST_MIX) |-> (c_q <= val_q && x_q <= c_q))
		else $error("chroma terms out of range at mix");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.st_sel == hrpd_pkg::ST_OUT && out_free) |=> out_valid_q)
		else $error("result not loaded into output register");

endmodule

/* sim/hrpd_duty_checker.sv */
// Checker: tracks LED levels and config, predicts each duty result and compares it.
`timescale 1ns / 1ps

module hrpd_duty_checker
	import hrpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	hrpd_in_if                    in_ch,
	hrpd_out_if                   out_ch,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [3:0]  channel;
		logic [11:0] first;
		logic [11:0] second;
		logic [11:0] third;
	} duty_set_t;

	duty_set_t  duty_q[$];
	logic       rgb_order;
	logic [3:0] chan_base;
	logic [7:0] red_lvl;
	logic [7:0] green_lvl;
	logic [7:0] blue_lvl;
	int         err_cnt = 0;
	int         waiting = 0;

	assign errors  = err_cnt;
	assign pending = waiting;

	function automatic logic [11:0] duty_of(input logic [7:0] lv);
		logic [19:0] prod;
		prod = 20'(lv) * 20'd4095;
		return 12'(prod / 20'd255);
	endfunction

	// returns {red, green, blue}
	function automatic logic [23:0] hsv_levels(input logic [8:0] hue_in,
			input logic [7:0] sat, input logic [7:0] val);
		logic [8:0]  h;
		logic [15:0] c, x, m, rem, dev, r, g, b;
		h = (hue_in >= 9'd360) ? hue_in - 9'd360 : hue_in;
		c = (16'(val) * 16'(sat)) / 16'd255;
		rem = 16'(h) % 16'd120;
		dev = (rem >= 16'd60) ? rem - 16'd60 : 16'd60 - rem;
		x = (c * (16'd60 - dev)) / 16'd60;
		m = 16'(val) - c;
		case (h / 9'd60)
			9'd0:    begin r = c;     g = x;     b = 16'd0; end
			9'd1:    begin r = x;     g = c;     b = 16'd0; end
			9'd2:    begin r = 16'd0; g = c;     b = x;     end
			9'd3:    begin r = 16'd0; g = x;     b = c;     end
			9'd4:    begin r = x;     g = 16'd0; b = c;     end
			default: begin r = c;     g = 16'd0; b = x;     end
		endcase
		r = r + m;
		g = g + m;
		b = b + m;
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

	task automatic check_field(input string what, input logic [11:0] want,
			input logic [11:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		duty_set_t want;
		duty_set_t nxt;
		logic [11:0] rd, gd;
		if (!arst_n) begin
			rgb_order = 1'b0;
			chan_base = '0;
			red_lvl   = '0;
			green_lvl = '0;
			blue_lvl  = '0;
			duty_q.delete();
			waiting = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (duty_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result expected none actual ch %0d duties %0d %0d %0d",
						$time, out_ch.pwm_channel, out_ch.first_duty, out_ch.second_duty,
						out_ch.third_duty);
				end else begin
					want = duty_q.pop_front();
					check_field("pwm_channel", 12'(want.channel), 12'(out_ch.pwm_channel));
					check_field("first_duty", want.first, out_ch.first_duty);
					check_field("second_duty", want.second, out_ch.second_duty);
					check_field("third_duty", want.third, out_ch.third_duty);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLOR_ORDER:  rgb_order = cfg_data[0];
					CFG_CHANNEL_BASE: chan_base = cfg_data;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.command)
					CMD_SET_ALL: begin
						red_lvl   = in_ch.red_in;
						green_lvl = in_ch.green_in;
						blue_lvl  = in_ch.blue_in;
					end
					CMD_SET_RED:   red_lvl   = in_ch.level;
					CMD_SET_GREEN: green_lvl = in_ch.level;
					CMD_SET_BLUE:  blue_lvl  = in_ch.level;
					CMD_SET_HSV:
						{red_lvl, green_lvl, blue_lvl} =
							hsv_levels(in_ch.hue, in_ch.saturation, in_ch.brightness);
					default: ;
				endcase
				rd = duty_of(red_lvl);
				gd = duty_of(green_lvl);
				nxt.channel = chan_base;
				nxt.first   = rgb_order ? rd : gd;
				nxt.second  = rgb_order ? gd : rd;
				nxt.third   = duty_of(blue_lvl);
				duty_q.push_back(nxt);
			end
			waiting = duty_q.size();
		end
	end

endmodule

/* sim/tb_hsv_rgb_led_pwm_driver.sv */
// Testbench top: clock, reset, command stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb_hsv_rgb_led_pwm_driver;
	import hrpd_pkg::*;

	typedef struct {
		logic [2:0] cmd;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] lvl;
		logic [8:0] hue;
		logic [7:0] sat;
		logic [7:0] bri;
	} led_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	int                    burst_left = 0;
	int                    hold_reqs = 0;

	hrpd_in_if  in_ch ();
	hrpd_out_if out_ch ();

	hsv_rgb_led_pwm_driver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	hrpd_duty_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#10ms;
		$display("tb_hsv_rgb_led_pwm_driver: errors");
		$finish;
	end

	// all calls start right after a rising edge
	task automatic send_cmd(input led_cmd_t it);
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid      <= 1'b1;
		in_ch.command    <= it.cmd;
		in_ch.red_in     <= it.red;
		in_ch.green_in   <= it.green;
		in_ch.blue_in    <= it.blue;
		in_ch.level      <= it.lvl;
		in_ch.hue        <= it.hue;
		in_ch.saturation <= it.sat;
		in_ch.brightness <= it.bri;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
	endtask

	task automatic send_fields(input logic [2:0] cmd, input logic [7:0] r, g, b, lvl,
			input logic [8:0] hue, input logic [7:0] sat, bri);
		led_cmd_t it;
		it = '{cmd, r, g, b, lvl, hue, sat, bri};
		send_cmd(it);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_cfg(input logic order, input logic [3:0] base);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_COLOR_ORDER;
		cfg_data  <= {3'($urandom), order};
		@(posedge clk);
		cfg_index <= CFG_CHANNEL_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic led_cmd_t rand_cmd();
		led_cmd_t it;
		int k;
		k = $urandom_range(0, 99);
		if (k < 40)
			it.cmd = CMD_SET_HSV;
		else if (k < 58)
			it.cmd = CMD_SET_ALL;
		else if (k < 88)
			it.cmd = 3'($urandom_range(CMD_SET_RED, CMD_SET_BLUE));
		else
			it.cmd = 3'($urandom_range(5, 7));
		it.red   = rand_byte();
		it.green = rand_byte();
		it.blue  = rand_byte();
		it.lvl   = rand_byte();
		it.sat   = rand_byte();
		it.bri   = rand_byte();
		case ($urandom_range(0, 19))
			0:       it.hue = 9'd360;
			1:       it.hue = 9'($urandom_range(361, 511));
			2:       it.hue = 9'd0;
			3:       it.hue = 9'd359;
			4:       it.hue = 9'(60 * $urandom_range(0, 5) + $urandom_range(0, 2) - 1 + 1);
			default: it.hue = 9'($urandom_range(0, 359));
		endcase
		return it;
	endfunction

	// receiver back-pressure, with long holds on request
	initial begin
		int seg_left;
		int mode;
		int stall_left;
		int holds_done;
		seg_left = 0;
		mode = 0;
		stall_left = 0;
		holds_done = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (seg_left <= 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (holds_done != hold_reqs) begin
				holds_done++;
				stall_left = 300;
				out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0:       out_ch.ready <= 1'b1;
					1:       out_ch.ready <= 1'($urandom_range(0, 1));
					2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin
		logic       orders[4];
		logic [3:0] bases[4];
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.command    = '0;
		in_ch.red_in     = '0;
		in_ch.green_in   = '0;
		in_ch.blue_in    = '0;
		in_ch.level      = '0;
		in_ch.hue        = '0;
		in_ch.saturation = '0;
		in_ch.brightness = '0;
		orders = '{1'b1, 1'b0, 1'b1, 1'b0};
		bases  = '{4'd15, 4'd7, 4'd0, 4'd15};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config, field extremes, every command, hue sectors and wrap
		send_fields(CMD_SET_ALL,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   8'd0,   8'd0);
		send_fields(CMD_SET_ALL,   8'd255, 8'd255, 8'd255, 8'd0,   9'd0,   8'd0,   8'd0);
		send_fields(CMD_SET_RED,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   8'd0,   8'd0);
		send_fields(CMD_SET_GREEN, 8'd255, 8'd0,   8'd0,   8'd128, 9'd0,   8'd0,   8'd0);
		send_fields(CMD_SET_BLUE,  8'd0,   8'd255, 8'd0,   8'd1,   9'd0,   8'd0,   8'd0);
		send_fields(CMD_SET_RED,   8'd0,   8'd0,   8'd0,   8'd255, 9'd0,   8'd0,   8'd0);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   8'd255, 8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd60,  8'd255, 8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd120, 8'd255, 8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd180, 8'd200, 8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd240, 8'd255, 8'd100);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd300, 8'd128, 8'd200);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd359, 8'd255, 8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd360, 8'd255, 8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd511, 8'd255, 8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd59,  8'd0,   8'd255);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd61,  8'd255, 8'd0);
		send_fields(CMD_SET_HSV,   8'd0,   8'd0,   8'd0,   8'd0,   9'd90,  8'd1,   8'd1);
		send_fields(3'd5,          8'd9,   8'd9,   8'd9,   8'd9,   9'd9,   8'd9,   8'd9);
		send_fields(3'd6,          8'd255, 8'd255, 8'd255, 8'd255, 9'd511, 8'd255, 8'd255);
		send_fields(3'd7,          8'd0,   8'd0,   8'd0,   8'd0,   9'd0,   8'd0,   8'd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(orders[ph], bases[ph]);
			for (int n = 0; n < 470; n++) begin
				if ((ph == 0 || ph == 2) && n == 60)
					hold_reqs++;
				send_cmd(rand_cmd());
			end
			drain();
		end

		if (errors == 0)
			$display("tb_hsv_rgb_led_pwm_driver: clean");
		else
			$display("tb_hsv_rgb_led_pwm_driver: errors");
		$finish;
	end

endmodule
